// ===== hw/rtl/vsat_pkg.sv =====
// ----------------------------------------------------------------------------
// vsat_pkg
// Types, constants and address helpers for the video scroll address and
// dot timing unit.
// ----------------------------------------------------------------------------
package vsat_pkg;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_CTRL_WRITE  = 3'd1,
    OP_MASK_WRITE  = 3'd2,
    OP_SCROLL_WRITE = 3'd3,
    OP_ADDR_WRITE  = 3'd4,
    OP_STATUS_READ = 3'd5,
    OP_DATA_WRITE  = 3'd6,
    OP_DATA_READ   = 3'd7
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       sprite_hit;
    logic       sprite_over;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [14:0] vram_address;
    logic [2:0]  fine_scroll_x;
    logic [8:0]  line_number;
    logic [8:0]  dot_number;
    logic        vblank_flag;
    logic        nmi_pulse;
    logic        rendering_on;
    logic [13:0] tile_fetch_address;
    logic [13:0] attr_fetch_address;
    logic [2:0]  attr_shift;
  } out_t;

  localparam logic [8:0] DOTS_PER_LINE  = 9'd341;
  localparam logic [8:0] SKIP_DOT       = 9'd340;
  localparam logic [8:0] LINES_PER_FRAME = 9'd262;
  localparam logic [8:0] PRERENDER_LINE = 9'd261;
  localparam logic [8:0] VBLANK_LINE    = 9'd241;
  localparam logic [8:0] VISIBLE_LINES  = 9'd240;
  localparam logic [8:0] VCOPY_FIRST    = 9'd280;
  localparam logic [8:0] VCOPY_LAST     = 9'd304;
  localparam logic [8:0] PREFETCH_FIRST = 9'd321;
  localparam logic [8:0] PREFETCH_LAST  = 9'd336;
  localparam logic [8:0] FETCH_LAST     = 9'd256;
  localparam logic [8:0] HCOPY_DOT      = 9'd257;
  localparam logic [8:0] FLAG_DOT       = 9'd1;
  localparam logic [4:0] COARSE_Y_LAST  = 5'd29;

  localparam logic [14:0] HORIZ_MASK    = 15'h041F;
  localparam logic [14:0] VERT_MASK     = 15'h7BE0;

  function automatic logic [14:0] step_coarse_x(input logic [14:0] v);
    logic [14:0] r;
    if (v[4:0] == 5'h1F) begin
      r = {v[14:11], ~v[10], v[9:5], 5'd0};
    end else begin
      r = v + 15'd1;
    end
    return r;
  endfunction

  function automatic logic [14:0] step_fine_y(input logic [14:0] v);
    logic [14:0] r;
    logic [4:0]  cy;
    logic        nt_y;
    cy   = v[9:5];
    nt_y = v[11];
    if (v[14:12] != 3'd7) begin
      r = v + 15'h1000;
    end else begin
      if (cy == COARSE_Y_LAST) begin
        cy   = 5'd0;
        nt_y = ~nt_y;
      end else if (cy == 5'h1F) begin
        cy = 5'd0;
      end else begin
        cy = cy + 5'd1;
      end
      r = {3'd0, nt_y, v[10], cy, v[4:0]};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/video_scroll_address_timing_unit_core.sv =====
// ----------------------------------------------------------------------------
// video_scroll_address_timing_unit_core
// Dot and scanline timing, scroll address registers and status flags.
//
// Usage:
//   Input channel in_*: one transaction per dot tick or CPU register access
//   (ctrl, mask, scroll, addr, status read, data write, data read).
//   Output channel out_*: exactly one result transaction per input, carrying
//   the VRAM address, fine x, line and dot, vblank, NMI request, status read
//   data and the background tile and attribute fetch addresses.
//   Throughput: one transaction per cycle, sustained while out_ready is high.
//   The state is updated as the input is accepted; the result lands in an
//   output register, backed by a one-entry skid register, so one more input
//   is taken while a result waits. in_ready drops only while the skid
//   register is full, and rises again the cycle after the receiver drains it.
//   Reset (synchronous, rst_n low): counters, addresses and flags clear,
//   the frame parity starts even, and both output registers empty.
// ----------------------------------------------------------------------------
module video_scroll_address_timing_unit_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  vsat_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output vsat_pkg::out_t out_data
);

  logic [8:0]  dot_r, dot_nxt;
  logic [8:0]  line_r, line_nxt;
  logic        even_r, even_nxt;
  logic [14:0] cur_r, cur_nxt;
  logic [14:0] tmp_r, tmp_nxt;
  logic [2:0]  fine_x_r, fine_x_nxt;
  logic        toggle_r, toggle_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic        vblank_r, vblank_nxt;
  logic        hit_r, hit_nxt;
  logic        over_r, over_nxt;
  logic [7:0]  latch_r, latch_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  vsat_pkg::out_t out_r, out_nxt;
  vsat_pkg::out_t skid_r, skid_nxt;
  vsat_pkg::out_t res;

  logic        in_fire;
  logic        rend;
  logic        pre, vis, fetch;
  logic [7:0]  rd;
  logic        nmi;
  logic [14:0] addr;
  logic [14:0] inc;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rend = mask_r[3] || mask_r[4];
  assign inc  = ctrl_r[2] ? 15'd32 : 15'd1;

  always_comb begin
    dot_nxt    = dot_r;
    line_nxt   = line_r;
    even_nxt   = even_r;
    cur_nxt    = cur_r;
    tmp_nxt    = tmp_r;
    fine_x_nxt = fine_x_r;
    toggle_nxt = toggle_r;
    ctrl_nxt   = ctrl_r;
    mask_nxt   = mask_r;
    vblank_nxt = vblank_r;
    hit_nxt    = hit_r;
    over_nxt   = over_r;
    latch_nxt  = latch_r;
    rd         = 8'd0;
    nmi        = 1'b0;
    pre        = 1'b0;
    vis        = 1'b0;
    fetch      = 1'b0;
    addr       = cur_r;

    case (in_data.op)
      vsat_pkg::OP_TICK: begin
        dot_nxt = dot_r + 9'd1;
        if (rend && !even_r && line_r == vsat_pkg::PRERENDER_LINE &&
            dot_nxt == vsat_pkg::SKIP_DOT) begin
          dot_nxt = vsat_pkg::DOTS_PER_LINE;
        end
        if (dot_nxt >= vsat_pkg::DOTS_PER_LINE) begin
          dot_nxt  = 9'd0;
          line_nxt = line_r + 9'd1;
          if (line_nxt >= vsat_pkg::LINES_PER_FRAME) begin
            line_nxt = 9'd0;
            even_nxt = ~even_r;
          end
        end
        pre   = line_nxt == vsat_pkg::PRERENDER_LINE;
        vis   = line_nxt < vsat_pkg::VISIBLE_LINES;
        fetch = (dot_nxt >= vsat_pkg::PREFETCH_FIRST && dot_nxt <= vsat_pkg::PREFETCH_LAST) ||
                (dot_nxt >= 9'd1 && dot_nxt <= vsat_pkg::FETCH_LAST);
        if (rend) begin
          if (pre && dot_nxt >= vsat_pkg::VCOPY_FIRST && dot_nxt <= vsat_pkg::VCOPY_LAST) begin
            cur_nxt = (cur_nxt & vsat_pkg::HORIZ_MASK) | (tmp_r & vsat_pkg::VERT_MASK);
          end
          if (pre || vis) begin
            if (fetch && dot_nxt[2:0] == 3'd0) begin
              cur_nxt = vsat_pkg::step_coarse_x(cur_nxt);
            end
            if (dot_nxt == vsat_pkg::FETCH_LAST) begin
              cur_nxt = vsat_pkg::step_fine_y(cur_nxt);
            end
            if (dot_nxt == vsat_pkg::HCOPY_DOT) begin
              cur_nxt = (cur_nxt & vsat_pkg::VERT_MASK) | (tmp_r & vsat_pkg::HORIZ_MASK);
            end
          end
        end
        if (in_data.sprite_hit) begin
          hit_nxt = 1'b1;
        end
        if (in_data.sprite_over) begin
          over_nxt = 1'b1;
        end
        if (line_nxt == vsat_pkg::VBLANK_LINE && dot_nxt == vsat_pkg::FLAG_DOT) begin
          vblank_nxt = 1'b1;
          nmi        = ctrl_r[7];
        end
        if (pre && dot_nxt == vsat_pkg::FLAG_DOT) begin
          vblank_nxt = 1'b0;
          hit_nxt    = 1'b0;
          over_nxt   = 1'b0;
        end
        addr = cur_nxt;
      end
      vsat_pkg::OP_CTRL_WRITE: begin
        latch_nxt = in_data.data;
        ctrl_nxt  = in_data.data;
        tmp_nxt   = {tmp_r[14:12], in_data.data[1:0], tmp_r[9:0]};
        nmi       = in_data.data[7] && vblank_r;
      end
      vsat_pkg::OP_MASK_WRITE: begin
        latch_nxt = in_data.data;
        mask_nxt  = in_data.data;
      end
      vsat_pkg::OP_SCROLL_WRITE: begin
        latch_nxt = in_data.data;
        if (!toggle_r) begin
          tmp_nxt    = {tmp_r[14:5], in_data.data[7:3]};
          fine_x_nxt = in_data.data[2:0];
        end else begin
          tmp_nxt = {in_data.data[2:0], tmp_r[11:10], in_data.data[7:3], tmp_r[4:0]};
        end
        toggle_nxt = ~toggle_r;
      end
      vsat_pkg::OP_ADDR_WRITE: begin
        latch_nxt = in_data.data;
        if (!toggle_r) begin
          tmp_nxt = {1'b0, in_data.data[5:0], tmp_r[7:0]};
        end else begin
          tmp_nxt = {tmp_r[14:8], in_data.data};
          cur_nxt = tmp_nxt;
        end
        toggle_nxt = ~toggle_r;
        addr       = cur_nxt;
      end
      vsat_pkg::OP_STATUS_READ: begin
        rd         = {vblank_r, hit_r, over_r, latch_r[4:0]};
        vblank_nxt = 1'b0;
        toggle_nxt = 1'b0;
        latch_nxt  = rd;
      end
      vsat_pkg::OP_DATA_WRITE: begin
        latch_nxt = in_data.data;
        cur_nxt   = cur_r + inc;
      end
      vsat_pkg::OP_DATA_READ: begin
        cur_nxt = cur_r + inc;
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase

    res.read_data          = rd;
    res.vram_address       = addr;
    res.fine_scroll_x      = fine_x_nxt;
    res.line_number        = line_nxt;
    res.dot_number         = dot_nxt;
    res.vblank_flag        = vblank_nxt;
    res.nmi_pulse          = nmi;
    res.rendering_on       = mask_nxt[3] || mask_nxt[4];
    res.tile_fetch_address = {2'b10, addr[11:0]};
    res.attr_fetch_address = {2'b10, addr[11:10], 4'b1111, addr[9:7], addr[4:2]};
    res.attr_shift         = {addr[6], addr[1], 1'b0};
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (skid_valid_r && (!out_valid_r || out_ready)) begin
      out_nxt        = skid_r;
      out_valid_nxt  = 1'b1;
      skid_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end else begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r        <= 9'd0;
      line_r       <= 9'd0;
      even_r       <= 1'b1;
      cur_r        <= 15'd0;
      tmp_r        <= 15'd0;
      fine_x_r     <= 3'd0;
      toggle_r     <= 1'b0;
      ctrl_r       <= 8'd0;
      mask_r       <= 8'd0;
      vblank_r     <= 1'b0;
      hit_r        <= 1'b0;
      over_r       <= 1'b0;
      latch_r      <= 8'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        dot_r    <= dot_nxt;
        line_r   <= line_nxt;
        even_r   <= even_nxt;
        cur_r    <= cur_nxt;
        tmp_r    <= tmp_nxt;
        fine_x_r <= fine_x_nxt;
        toggle_r <= toggle_nxt;
        ctrl_r   <= ctrl_nxt;
        mask_r   <= mask_nxt;
        vblank_r <= vblank_nxt;
        hit_r    <= hit_nxt;
        over_r   <= over_nxt;
        latch_r  <= latch_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
    dot_r < vsat_pkg::DOTS_PER_LINE)
    else $error("dot counter out of range");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_r < vsat_pkg::LINES_PER_FRAME)
    else $error("line counter out of range");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_nmi_in_vblank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.nmi_pulse) |-> out_r.vblank_flag)
    else $error("NMI requested outside vblank");

  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction produced no result");

endmodule

// ===== bench/video_scroll_address_timing_unit_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_scroll_address_timing_unit_core_test
// Self-checking bench for the scroll address and dot timing unit. A local
// model of the counters, address registers and status flags predicts every
// result transaction. The stimulus runs in this order: directed register
// accesses, mixed random traffic, and fine-y and coarse-y stepping from
// corner addresses.
// ----------------------------------------------------------------------------
module video_scroll_address_timing_unit_core_test;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  vsat_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vsat_pkg::out_t out_data;

  bit calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  vsat_pkg::out_t expected_results[$];

  logic [8:0] dot_ctr, line_ctr;
  logic even_frm;
  logic [14:0] cur_v, tmp_t;
  logic [2:0] fine_x_q;
  logic w_toggle;
  logic [7:0] ctrl_q, mask_q, latch_q;
  logic vbl_q, hit_q, ovf_q;

  video_scroll_address_timing_unit_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_unit_model();
    dot_ctr = '0;
    line_ctr = '0;
    even_frm = 1'b1;
    cur_v = '0;
    tmp_t = '0;
    fine_x_q = '0;
    w_toggle = 1'b0;
    ctrl_q = '0;
    mask_q = '0;
    latch_q = '0;
    vbl_q = 1'b0;
    hit_q = 1'b0;
    ovf_q = 1'b0;
  endfunction

  function automatic logic [14:0] next_coarse_x(logic [14:0] v);
    if (v[4:0] == 5'd31) begin
      return (v & 15'h7FE0) ^ 15'h0400;
    end
    return v + 15'd1;
  endfunction

  function automatic logic [14:0] next_fine_y(logic [14:0] v);
    logic [4:0] cy;
    logic [14:0] r;
    if (v[14:12] != 3'd7) begin
      return v + 15'h1000;
    end
    cy = v[9:5];
    r = v & 15'h0FFF;
    if (cy == 5'd29) begin
      cy = 5'd0;
      r = r ^ 15'h0800;
    end else if (cy == 5'd31) begin
      cy = 5'd0;
    end else begin
      cy = cy + 5'd1;
    end
    r[9:5] = cy;
    return r;
  endfunction

  // Advance the model by one input transaction and return its result.
  function automatic vsat_pkg::out_t apply_transaction(vsat_pkg::in_t t);
    vsat_pkg::out_t r;
    logic render, pre, vis, fetch;
    logic [14:0] shown;
    r = '0;
    shown = cur_v;
    render = mask_q[3] | mask_q[4];
    case (t.op)
      vsat_pkg::OP_TICK: begin
        dot_ctr = dot_ctr + 9'd1;
        if (render && !even_frm && line_ctr == 9'd261 && dot_ctr == 9'd340) begin
          dot_ctr = dot_ctr + 9'd1;
        end
        if (dot_ctr >= 9'd341) begin
          dot_ctr = '0;
          line_ctr = line_ctr + 9'd1;
          if (line_ctr >= 9'd262) begin
            line_ctr = '0;
            even_frm = ~even_frm;
          end
        end
        pre = line_ctr == 9'd261;
        vis = line_ctr < 9'd240;
        fetch = (dot_ctr >= 9'd321 && dot_ctr <= 9'd336) ||
                (dot_ctr >= 9'd1 && dot_ctr <= 9'd256);
        if (render) begin
          if (pre && dot_ctr >= 9'd280 && dot_ctr <= 9'd304) begin
            cur_v = (cur_v & 15'h041F) | (tmp_t & 15'h7BE0);
          end
          if (pre || vis) begin
            if (fetch && dot_ctr[2:0] == 3'd0) cur_v = next_coarse_x(cur_v);
            if (dot_ctr == 9'd256) cur_v = next_fine_y(cur_v);
            if (dot_ctr == 9'd257) cur_v = (cur_v & 15'h7BE0) | (tmp_t & 15'h041F);
          end
        end
        if (t.sprite_hit) hit_q = 1'b1;
        if (t.sprite_over) ovf_q = 1'b1;
        if (line_ctr == 9'd241 && dot_ctr == 9'd1) begin
          vbl_q = 1'b1;
          if (ctrl_q[7]) r.nmi_pulse = 1'b1;
        end
        if (pre && dot_ctr == 9'd1) begin
          vbl_q = 1'b0;
          hit_q = 1'b0;
          ovf_q = 1'b0;
        end
      end
      vsat_pkg::OP_CTRL_WRITE: begin
        latch_q = t.data;
        ctrl_q = t.data;
        tmp_t[11:10] = t.data[1:0];
        if (ctrl_q[7] && vbl_q) r.nmi_pulse = 1'b1;
      end
      vsat_pkg::OP_MASK_WRITE: begin
        latch_q = t.data;
        mask_q = t.data;
      end
      vsat_pkg::OP_SCROLL_WRITE: begin
        latch_q = t.data;
        if (!w_toggle) begin
          tmp_t[4:0] = t.data[7:3];
          fine_x_q = t.data[2:0];
        end else begin
          tmp_t[9:5] = t.data[7:3];
          tmp_t[14:12] = t.data[2:0];
        end
        w_toggle = ~w_toggle;
      end
      vsat_pkg::OP_ADDR_WRITE: begin
        latch_q = t.data;
        if (!w_toggle) begin
          tmp_t[13:8] = t.data[5:0];
          tmp_t[14] = 1'b0;
        end else begin
          tmp_t[7:0] = t.data;
          cur_v = tmp_t;
        end
        w_toggle = ~w_toggle;
      end
      vsat_pkg::OP_STATUS_READ: begin
        r.read_data = {vbl_q, hit_q, ovf_q, latch_q[4:0]};
        vbl_q = 1'b0;
        w_toggle = 1'b0;
        latch_q = r.read_data;
      end
      vsat_pkg::OP_DATA_WRITE: begin
        latch_q = t.data;
        cur_v = cur_v + (ctrl_q[2] ? 15'd32 : 15'd1);
      end
      default: begin
        cur_v = cur_v + (ctrl_q[2] ? 15'd32 : 15'd1);
      end
    endcase
    if (t.op != vsat_pkg::OP_DATA_WRITE && t.op != vsat_pkg::OP_DATA_READ) shown = cur_v;
    r.vram_address = shown;
    r.fine_scroll_x = fine_x_q;
    r.line_number = line_ctr;
    r.dot_number = dot_ctr;
    r.vblank_flag = vbl_q;
    r.rendering_on = mask_q[3] | mask_q[4];
    r.tile_fetch_address = {2'b10, shown[11:0]};
    r.attr_fetch_address = 14'h23C0 | {2'b00, shown[11:10], 10'd0} |
                           {8'd0, shown[9:7], 3'd0} | {11'd0, shown[4:2]};
    r.attr_shift = {shown[6], shown[1], 1'b0};
    return r;
  endfunction

  function automatic vsat_pkg::in_t pack_item(vsat_pkg::op_t op, logic [7:0] data,
                                              logic hit = 1'b0, logic over = 1'b0);
    vsat_pkg::in_t t;
    t.op = op;
    t.data = data;
    t.sprite_hit = hit;
    t.sprite_over = over;
    return t;
  endfunction

  task automatic send_item(input vsat_pkg::in_t item);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(apply_transaction(item));
    items_sent++;
  endtask

  task automatic send_tick(logic hit = 1'b0, logic over = 1'b0);
    send_item(pack_item(vsat_pkg::OP_TICK, 8'($urandom), hit, over));
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [14:0] got,
                               input logic [14:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    vsat_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
      end else begin
        want = expected_results.pop_front();
        compare_field("read_data", 15'(out_data.read_data), 15'(want.read_data));
        compare_field("vram_address", out_data.vram_address, want.vram_address);
        compare_field("fine_scroll_x", 15'(out_data.fine_scroll_x),
                      15'(want.fine_scroll_x));
        compare_field("line_number", 15'(out_data.line_number), 15'(want.line_number));
        compare_field("dot_number", 15'(out_data.dot_number), 15'(want.dot_number));
        compare_field("vblank_flag", 15'(out_data.vblank_flag), 15'(want.vblank_flag));
        compare_field("nmi_pulse", 15'(out_data.nmi_pulse), 15'(want.nmi_pulse));
        compare_field("rendering_on", 15'(out_data.rendering_on),
                      15'(want.rendering_on));
        compare_field("tile_fetch_address", 15'(out_data.tile_fetch_address),
                      15'(want.tile_fetch_address));
        compare_field("attr_fetch_address", 15'(out_data.attr_fetch_address),
                      15'(want.attr_fetch_address));
        compare_field("attr_shift", 15'(out_data.attr_shift), 15'(want.attr_shift));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && rst_n && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic test_register_basics();
    send_item(pack_item(vsat_pkg::OP_STATUS_READ, 8'h00));
    send_item(pack_item(vsat_pkg::OP_CTRL_WRITE, 8'hFF));
    send_item(pack_item(vsat_pkg::OP_MASK_WRITE, 8'hFF));
    send_item(pack_item(vsat_pkg::OP_SCROLL_WRITE, 8'hFF));
    send_item(pack_item(vsat_pkg::OP_SCROLL_WRITE, 8'hFF));
    send_item(pack_item(vsat_pkg::OP_SCROLL_WRITE, 8'hFF));
    // second addr write copies the full temp address, fine y included
    send_item(pack_item(vsat_pkg::OP_ADDR_WRITE, 8'hFF));
    send_item(pack_item(vsat_pkg::OP_DATA_READ, 8'h00));
    send_item(pack_item(vsat_pkg::OP_CTRL_WRITE, 8'h00));
    send_item(pack_item(vsat_pkg::OP_ADDR_WRITE, 8'hFF));
    send_item(pack_item(vsat_pkg::OP_ADDR_WRITE, 8'hFF));
    send_item(pack_item(vsat_pkg::OP_DATA_WRITE, 8'hA5));
    send_item(pack_item(vsat_pkg::OP_DATA_READ, 8'hFF, 1'b1, 1'b1));
    send_item(pack_item(vsat_pkg::OP_STATUS_READ, 8'h00));
    send_item(pack_item(vsat_pkg::OP_MASK_WRITE, 8'h18));
    send_tick(1'b1, 1'b1);
    send_item(pack_item(vsat_pkg::OP_CTRL_WRITE, 8'h00, 1'b1, 1'b1));
    send_item(pack_item(vsat_pkg::OP_STATUS_READ, 8'hFF));
    send_item(pack_item(vsat_pkg::OP_MASK_WRITE, 8'h00));
    send_item(pack_item(vsat_pkg::OP_SCROLL_WRITE, 8'h00));
    send_item(pack_item(vsat_pkg::OP_SCROLL_WRITE, 8'h00));
    send_item(pack_item(vsat_pkg::OP_ADDR_WRITE, 8'h00));
    send_item(pack_item(vsat_pkg::OP_ADDR_WRITE, 8'h00));
    send_tick(1'b0, 1'b0);
    send_item(pack_item(vsat_pkg::OP_MASK_WRITE, 8'h10));
  endtask

  task automatic test_random_traffic();
    int unsigned base;
    int unsigned pick;
    logic [7:0] m;
    logic [12:0] raw;
    base = items_sent;
    while (items_sent - base < 400) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: send_tick($urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        4: begin
          send_item(pack_item(vsat_pkg::OP_STATUS_READ, 8'($urandom), 1'($urandom),
                              1'($urandom)));
          send_item(pack_item(vsat_pkg::OP_SCROLL_WRITE, 8'($urandom)));
          send_item(pack_item(vsat_pkg::OP_SCROLL_WRITE, 8'($urandom)));
        end
        5: begin
          send_item(pack_item(vsat_pkg::OP_STATUS_READ, 8'($urandom)));
          send_item(pack_item(vsat_pkg::OP_ADDR_WRITE, 8'($urandom)));
          send_item(pack_item(vsat_pkg::OP_ADDR_WRITE, 8'($urandom)));
        end
        6: send_item(pack_item(vsat_pkg::OP_CTRL_WRITE, 8'($urandom), 1'($urandom),
                               1'($urandom)));
        7: begin
          m = 8'($urandom);
          if ($urandom_range(0, 3) != 0) m[3] = 1'b1;
          send_item(pack_item(vsat_pkg::OP_MASK_WRITE, m));
        end
        8: send_item(pack_item($urandom_range(0, 1) ? vsat_pkg::OP_DATA_WRITE :
                               vsat_pkg::OP_DATA_READ,
                               8'($urandom), 1'($urandom), 1'($urandom)));
        default: begin
          raw = 13'($urandom);
          send_item(vsat_pkg::in_t'(raw));
        end
      endcase
    end
  endtask

  task automatic test_address_stepping();
    logic [2:0] fy;
    logic [4:0] cy, cx;
    logic [7:0] c;
    int unsigned k;
    for (k = 0; k < 2; k++) begin
      fy = (k < 12) ? 3'd7 : 3'($urandom);
      case (k % 4)
        0: cy = 5'd29;
        1: cy = 5'd31;
        2: cy = 5'd30;
        default: cy = 5'($urandom);
      endcase
      cx = (k % 3 == 0) ? 5'd31 : 5'($urandom);
      c = 8'($urandom);
      send_item(pack_item(vsat_pkg::OP_CTRL_WRITE, c & 8'h7F));
      send_item(pack_item(vsat_pkg::OP_MASK_WRITE,
                          8'($urandom) | ((k % 2 == 0) ? 8'h08 : 8'h10)));
      send_item(pack_item(vsat_pkg::OP_STATUS_READ, 8'($urandom)));
      send_item(pack_item(vsat_pkg::OP_SCROLL_WRITE, 8'($urandom)));
      send_item(pack_item(vsat_pkg::OP_SCROLL_WRITE, {cy, fy}));
      send_item(pack_item(vsat_pkg::OP_SCROLL_WRITE, 8'($urandom)));
      send_item(pack_item(vsat_pkg::OP_ADDR_WRITE, {cy[2:0], cx}));
      // run past the fine y step and the horizontal copy
      do begin
        send_tick(1'b0, 1'b0);
      end while (dot_ctr != 9'd258);
    end
  endtask

  initial begin
    clear_unit_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_basics();
    test_random_traffic();
    calm = 1'b1;
    test_address_stepping();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** video_scroll_address_timing_unit_core: PASSED **");
    end else begin
      $display("** video_scroll_address_timing_unit_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("** video_scroll_address_timing_unit_core: FAILED **");
    $finish;
  end

endmodule
